### hdl/sha1_message_digest_assert.svh
// ----------------------------------------------------------------------------
// SHA-1 digest assertion macros
// Shared concurrent assertion forms, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// same-cycle implication
`define SHA1MD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA1MD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Shared types, constants and control structs of the SHA-1 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] hash_t;     // index 0 = h0 / a
  typedef logic [3:0]  pos_t;
  typedef logic [6:0]  rnd_t;
  typedef logic [2:0]  nbytes_t;
  typedef logic [63:0] bitcnt_t;

  localparam hash_t IV = '{
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam int   ROUNDS    = 80;
  localparam rnd_t RND_SEG1  = 7'd20;
  localparam rnd_t RND_SEG2  = 7'd40;
  localparam rnd_t RND_SEG3  = 7'd60;
  localparam rnd_t LAST_RND  = 7'(ROUNDS - 1);

  localparam pos_t  LEN_POS    = 4'd14;
  localparam pos_t  LAST_POS   = 4'd15;
  localparam word_t PAD_WORD   = 32'h8000_0000;
  localparam nbytes_t FULL_BYTES = 3'd4;
  localparam int    DIGEST_WORDS = 5;

  typedef struct packed {
    logic  push;   // shift one word into the block window
    word_t word;
    logic  init;   // chain back to IV, fill position to zero
  } cmp_ctrl_t;

  typedef struct packed {
    logic busy;    // rounds or fold in progress
    pos_t pos;     // block fill position
  } cmp_stat_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

`default_nettype wire

### hdl/sha1md_in_if.sv
// ----------------------------------------------------------------------------
// SHA-1 message word channel
// Valid/ready channel carrying one message word with its byte count.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1md_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last;

  modport source (output valid, data_word, valid_bytes, last, input ready);
  modport sink   (input valid, data_word, valid_bytes, last, output ready);
endinterface

`default_nettype wire

### hdl/sha1md_out_if.sv
// ----------------------------------------------------------------------------
// SHA-1 digest word channel
// Valid/ready channel carrying one digest word with its index.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

### hdl/sha1md_round.sv
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: selects f and K by round number, forms the new a.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_round (
  input  sha1md_pkg::hash_t vars_i,
  input  sha1md_pkg::word_t wt_i,
  input  sha1md_pkg::rnd_t  rnd_i,
  output sha1md_pkg::hash_t vars_o
);
  import sha1md_pkg::*;

  word_t a, b, c, d, e;
  word_t f, k;

  assign a = vars_i[0];
  assign b = vars_i[1];
  assign c = vars_i[2];
  assign d = vars_i[3];
  assign e = vars_i[4];

  always_comb begin
    if (rnd_i < RND_SEG1) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd_i < RND_SEG2) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd_i < RND_SEG3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign vars_o[0] = rotl(a, 5) + f + e + k + wt_i;
  assign vars_o[1] = a;
  assign vars_o[2] = rotl(b, 30);
  assign vars_o[3] = c;
  assign vars_o[4] = d;

endmodule

`default_nettype wire

### hdl/sha1md_compress.sv
// ----------------------------------------------------------------------------
// SHA-1 block compressor
// 16-word window, working variables and chain; runs the round unit 80 times
// per block, then folds the result into the chain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_message_digest_assert.svh"

module sha1md_compress (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  sha1md_pkg::cmp_ctrl_t  ctrl_i,
  output sha1md_pkg::cmp_stat_t  stat_o,
  output sha1md_pkg::hash_t      chain_o
);
  import sha1md_pkg::*;

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FOLD = 2'd2;

  logic [1:0]   state_q, state_d;
  pos_t         pos_q, pos_d;
  rnd_t         rnd_q, rnd_d;
  hash_t        chain_q, chain_d;
  hash_t        vars_q, vars_d;
  word_t [15:0] win_q, win_d;   // win_q[0] is the oldest word
  hash_t        vars_nxt;
  word_t        w_new;

  assign w_new = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);

  sha1md_round u_round (
    .vars_i (vars_q),
    .wt_i   (win_q[0]),
    .rnd_i  (rnd_q),
    .vars_o (vars_nxt)
  );

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    rnd_d   = rnd_q;
    chain_d = chain_q;
    vars_d  = vars_q;
    win_d   = win_q;
    case (state_q)
      ST_FILL: begin
        if (ctrl_i.init) begin
          chain_d = IV;
          pos_d   = '0;
        end else if (ctrl_i.push) begin
          win_d = {ctrl_i.word, win_q[15:1]};
          pos_d = pos_q + 4'd1;
          if (pos_q == LAST_POS) begin
            vars_d  = chain_q;
            rnd_d   = '0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        vars_d = vars_nxt;
        win_d  = {w_new, win_q[15:1]};
        rnd_d  = rnd_q + 7'd1;
        if (rnd_q == LAST_RND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain_d[i] = chain_q[i] + vars_q[i];
        end
        state_d = ST_FILL;
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      pos_q   <= '0;
      rnd_q   <= '0;
      chain_q <= IV;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rnd_q   <= rnd_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    win_q  <= win_d;
  end

  assign stat_o.busy = (state_q != ST_FILL);
  assign stat_o.pos  = pos_q;
  assign chain_o     = chain_q;

  `SHA1MD_ASSERT_IMP(a_push_when_fill, clk_i, rst_ni, ctrl_i.push, state_q == ST_FILL, "word pushed during compression")
  `SHA1MD_ASSERT_NXT(a_run_to_fold, clk_i, rst_ni, state_q == ST_RUN && rnd_q == LAST_RND, state_q == ST_FOLD, "round 79 not followed by fold")
  `SHA1MD_ASSERT_NXT(a_fold_to_fill, clk_i, rst_ni, state_q == ST_FOLD, state_q == ST_FILL && pos_q == 4'd0, "fold left a partial block")

endmodule

`default_nettype wire

### hdl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Buffers message words, pads the last one, runs the block compressor and
// returns the five digest words.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              ends on
//  in_i      in   data_word, valid_bytes, last         last = 1
//  out_o     out  digest_word, word_index, last_word   last_word = 1
//
//  A word is taken while in_i.ready is high. The 16th word of a block starts
//  the shared round unit, 80 rounds at one per cycle, then the fold, with
//  in_i.ready low. A last word is followed by pad words and the bit length
//  over one or two blocks, then five digest words are offered, one per cycle
//  while out_o.ready is high.
//  Asynchronous active-low reset loads the SHA-1 initial chain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_message_digest_assert.svh"

module sha1_message_digest (
  input  wire          clk_i,
  input  wire          rst_ni,
  sha1md_in_if.sink    in_i,
  sha1md_out_if.source out_o
);
  import sha1md_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD80 = 3'd1;
  localparam logic [2:0] ST_PAD   = 3'd2;
  localparam logic [2:0] ST_LENLO = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  bitcnt_t    bits_q, bits_d;
  logic [2:0] idx_q, idx_d;
  cmp_ctrl_t  ctrl;
  cmp_stat_t  stat;
  hash_t      chain;
  nbytes_t    nb;
  word_t      tail_word;
  logic       in_acc, out_acc;

  sha1md_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .chain_o (chain)
  );

  assign in_i.ready = (state_q == ST_IDLE) && !stat.busy;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  assign nb = (in_i.valid_bytes > FULL_BYTES) ? FULL_BYTES : in_i.valid_bytes;

  always_comb begin
    case (nb[1:0])
      2'd1:    tail_word = {in_i.data_word[31:24], 24'h80_0000};
      2'd2:    tail_word = {in_i.data_word[31:16], 16'h8000};
      2'd3:    tail_word = {in_i.data_word[31:8], 8'h80};
      default: tail_word = PAD_WORD;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    bits_d    = bits_q;
    idx_d     = idx_q;
    ctrl.push = 1'b0;
    ctrl.word = '0;
    ctrl.init = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.push = 1'b1;
          if (!in_i.last) begin
            ctrl.word = in_i.data_word;
            bits_d    = bits_q + 64'd32;
          end else begin
            bits_d = bits_q + {58'd0, nb, 3'd0};
            if (nb == FULL_BYTES) begin
              ctrl.word = in_i.data_word;
              state_d   = ST_PAD80;
            end else begin
              ctrl.word = tail_word;
              state_d   = ST_PAD;
            end
          end
        end
      end
      ST_PAD80: begin
        if (!stat.busy) begin
          ctrl.push = 1'b1;
          ctrl.word = PAD_WORD;
          state_d   = ST_PAD;
        end
      end
      ST_PAD: begin
        if (!stat.busy) begin
          ctrl.push = 1'b1;
          if (stat.pos == LEN_POS) begin
            ctrl.word = bits_q[63:32];
            state_d   = ST_LENLO;
          end
        end
      end
      ST_LENLO: begin
        if (!stat.busy) begin
          ctrl.push = 1'b1;
          ctrl.word = bits_q[31:0];
          state_d   = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!stat.busy) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'(DIGEST_WORDS - 1)) begin
            ctrl.init = 1'b1;
            bits_d    = '0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bits_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      bits_q  <= bits_d;
      idx_q   <= idx_d;
    end
  end

  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.digest_word = chain[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'(DIGEST_WORDS - 1));

  `SHA1MD_ASSERT_NXT(a_last_blocks_input, clk_i, rst_ni, in_acc && in_i.last, !in_i.ready, "word taken while padding")
  `SHA1MD_ASSERT_IMP(a_out_after_fold, clk_i, rst_ni, out_o.valid, !stat.busy, "digest offered during compression")
  `SHA1MD_ASSERT_NXT(a_clean_restart, clk_i, rst_ni, out_acc && out_o.last_word, state_q == ST_IDLE && stat.pos == 4'd0 && bits_q == 64'd0, "state not cleared after digest")

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams directed and random messages into the digest block under four
// pacing phases. A local SHA-1 model predicts the five digest words of each
// message, and every digest word taken from the block is checked against it.
// ----------------------------------------------------------------------------
module tb;
  import sha1md_pkg::*;

  typedef struct {
    word_t      data;
    logic [2:0] nbytes;
    logic       last;
  } msg_word_t;

  typedef struct {
    word_t      digest;
    logic [2:0] index;
    logic       last;
  } digest_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha1md_in_if  in_bus ();
  sha1md_out_if out_bus ();

  sha1_message_digest DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #1 clk_i = ~clk_i;

  msg_word_t    word_queue[$];
  digest_word_t digest_queue[$];

  word_t       chain[5];
  word_t       blk_words[16];
  logic [63:0] bit_count;
  logic [3:0]  fill_pos;

  int tx_idle_pct;
  int rx_stall_pct;
  int words_sent;
  int words_taken;
  int digests_checked;
  int messages_queued;
  int error_count;
  bit in_fire;
  bit out_fire;

  function automatic void reset_chain();
    int i;
    for (i = 0; i < 5; i++) chain[i] = IV[i];
    bit_count = '0;
    fill_pos  = '0;
  endfunction

  function automatic void compress_block();
    word_t w [16];
    word_t a, b, c, d, e, f, k, wt, sum;
    int t;
    w = blk_words;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16];
        wt = {wt[30:0], wt[31]};
        w[t % 16] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + wt;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endfunction

  function automatic void load_block_word(input word_t w);
    blk_words[fill_pos] = w;
    fill_pos = fill_pos + 4'd1;
    if (fill_pos == 4'd0) compress_block();
  endfunction

  // Absorb one message word; a last word pads, finishes and queues the digest.
  function automatic void predict_digest(input word_t data, input logic [2:0] vb,
                                         input logic lst);
    int nb;
    int i;
    word_t mask;
    digest_word_t dw;
    if (!lst) begin
      bit_count = bit_count + 64'd32;
      load_block_word(data);
      return;
    end
    nb = (vb > 3'd4) ? 4 : int'(vb);
    bit_count = bit_count + 64'(nb * 8);
    if (nb == 4) begin
      load_block_word(data);
      load_block_word(PAD_WORD);
    end else begin
      mask = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
      load_block_word((data & mask) | (32'h80 << (24 - 8 * nb)));
    end
    if (fill_pos > LEN_POS) begin
      while (fill_pos != 4'd0) load_block_word(32'h0);
    end
    while (fill_pos < LEN_POS) load_block_word(32'h0);
    load_block_word(bit_count[63:32]);
    load_block_word(bit_count[31:0]);
    for (i = 0; i < DIGEST_WORDS; i++) begin
      dw.digest = chain[i];
      dw.index  = 3'(i);
      dw.last   = (i == DIGEST_WORDS - 1);
      digest_queue = {digest_queue, dw};
    end
    reset_chain();
  endfunction

  // Sampling side: handshakes, prediction and digest check.
  always @(posedge clk_i) begin
    digest_word_t want;
    in_fire  = in_bus.valid && in_bus.ready;
    out_fire = out_bus.valid && out_bus.ready;
    if (rst_ni && in_fire) begin
      predict_digest(in_bus.data_word, in_bus.valid_bytes, in_bus.last);
      words_taken++;
    end
    if (rst_ni && out_fire) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest word %h index %0d", out_bus.digest_word,
               out_bus.word_index);
        error_count++;
      end else begin
        want = digest_queue.pop_front();
        digests_checked++;
        if (out_bus.digest_word !== want.digest) begin
          $error("digest_word mismatch: expected %h, got %h", want.digest,
                 out_bus.digest_word);
          error_count++;
        end
        if (out_bus.word_index !== want.index) begin
          $error("word_index mismatch: expected %0d, got %0d", want.index,
                 out_bus.word_index);
          error_count++;
        end
        if (out_bus.last_word !== want.last) begin
          $error("last_word mismatch: expected %0b, got %0b", want.last,
                 out_bus.last_word);
          error_count++;
        end
      end
    end
  end

  // Driving side: message words and digest ready, both on the falling edge.
  always @(negedge clk_i) begin
    msg_word_t nxt;
    if (rst_ni && !(in_bus.valid && !in_fire)) begin
      if (word_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = word_queue.pop_front();
        words_sent++;
        in_bus.valid       <= 1'b1;
        in_bus.data_word   <= nxt.data;
        in_bus.valid_bytes <= nxt.nbytes;
        in_bus.last        <= nxt.last;
      end else begin
        in_bus.valid       <= 1'b0;
        in_bus.data_word   <= $urandom;
        in_bus.valid_bytes <= 3'($urandom);
        in_bus.last        <= 1'($urandom);
      end
    end
    if (rst_ni) out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic add_word(input word_t data, input logic [2:0] nb, input logic lst);
    msg_word_t w;
    w.data   = data;
    w.nbytes = nb;
    w.last   = lst;
    word_queue = {word_queue, w};
    if (lst) messages_queued++;
  endtask

  function automatic word_t rand_data();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Half short messages, a quarter near the block boundary, a quarter multi-block.
  task automatic queue_random_message(output int n);
    int len;
    int i;
    case ($urandom_range(3))
      0:       len = $urandom_range(12, 17);
      1:       len = $urandom_range(28, 34);
      default: len = $urandom_range(0, 11);
    endcase
    for (i = 0; i < len; i++)
      add_word(rand_data(), ($urandom_range(3) == 0) ? 3'($urandom) : FULL_BYTES, 1'b0);
    add_word(rand_data(), 3'($urandom_range(7)), 1'b1);
    n = len + 1;
  endtask

  task automatic drain();
    while (word_queue.size() > 0 || words_taken != words_sent || digest_queue.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(input int tx, input int rx, input int budget);
    int n;
    int count;
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    count = 0;
    while (count < budget) begin
      queue_random_message(n);
      count += n;
    end
    drain();
  endtask

  initial begin
    int i;
    in_bus.valid       = 1'b0;
    in_bus.data_word   = '0;
    in_bus.valid_bytes = '0;
    in_bus.last        = 1'b0;
    out_bus.ready      = 1'b0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    words_sent      = 0;
    words_taken     = 0;
    digests_checked = 0;
    messages_queued = 0;
    error_count     = 0;
    reset_chain();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty message, then short tails of every byte count
    add_word(32'h0, 3'd0, 1'b1);
    add_word(32'h6162_6300, 3'd3, 1'b1);
    add_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    add_word(32'hFFFF_FFFF, 3'd2, 1'b1);
    add_word(32'hFFFF_FFFF, FULL_BYTES, 1'b1);
    // oversized byte counts saturate
    add_word(32'h0, 3'd5, 1'b1);
    add_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    // byte count ignored on a middle word
    add_word(32'h0, 3'd0, 1'b0);
    add_word(32'hFFFF_FFFF, 3'd6, 1'b1);
    // padding spills into an extra block
    for (i = 0; i < 13; i++)
      add_word((i % 2) ? 32'hFFFF_FFFF : 32'h0, 3'(i % 4), 1'b0);
    add_word(32'hA5A5_5A5A, FULL_BYTES, 1'b1);
    drain();

    run_phase(0, 0, 120);
    run_phase(59, 0, 125);
    run_phase(0, 59, 125);
    run_phase(17, 17, 125);

    repeat (400) @(posedge clk_i);
    $display("covered %0d messages, %0d message words, %0d digest words checked",
             messages_queued, words_taken, digests_checked);
    $display("pacing: free-running, sender gaps, receiver stalls, and both combined");
    if (error_count == 0) begin
      $display("sha1_message_digest regression: pass");
    end else begin
      $display("sha1_message_digest regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sha1_message_digest regression: fail");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/sha1md_pkg.sv
hdl/sha1md_in_if.sv
hdl/sha1md_out_if.sv
hdl/sha1md_round.sv
hdl/sha1md_compress.sv
hdl/sha1_message_digest.sv
sim/tb.sv
